[hdl/tahd_pkg.sv]
// shared constants, types and helpers for the tile average halftone dot block
package tahd_pkg;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_TILE_SIZE    = 2'd0;
   localparam csr_index_type REG_TILES_ACROSS = 2'd1;
   localparam csr_index_type REG_TILES_DOWN   = 2'd2;

   localparam int DEF_MAX_TILES_ACROSS = 1024;
   localparam int DEF_MAX_TILE_SIZE    = 64;
   localparam int MAX_TILES_DOWN       = 1024;

   localparam logic [6:0]  RST_TILE_SIZE    = 7'd8;
   localparam logic [10:0] RST_TILES_ACROSS = 11'd80;
   localparam logic [10:0] RST_TILES_DOWN   = 11'd60;

   localparam int ROW_W     = 10;
   localparam int OUT_COL_W = 10;
   localparam int PIX_W     = 8;
   localparam int Q_W       = 10;
   localparam int FULL_RGB  = 765;
   localparam int FIFO_DEPTH = 4;

   function automatic int width_of(input int n);
      width_of = (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

[hdl/tahd_fifo.sv]
// short queue between the tile front end and the divide back end
module tahd_fifo import tahd_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = width_of(FIFO_DEPTH);

   logic [WIDTH-1:0] slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full     = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

[hdl/tahd_front.sv]
// raster walker and per-column tile sum accumulation
module tahd_front import tahd_pkg::*; #(
   parameter int MAX_TILES_ACROSS = DEF_MAX_TILES_ACROSS,
   parameter int MAX_TILE_SIZE    = DEF_MAX_TILE_SIZE,
   localparam int X_W   = width_of(MAX_TILE_SIZE),
   localparam int COL_W = width_of(MAX_TILES_ACROSS),
   localparam int SUM_W = PIX_W + width_of(MAX_TILE_SIZE * MAX_TILE_SIZE + 1),
   localparam int ENT_W = 1 + ROW_W + COL_W + 3 * SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [X_W-1:0]   last_x_idx,
   input  logic [COL_W-1:0] last_col_idx,
   input  logic [ROW_W-1:0] last_row_idx,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   output logic             push,
   output logic [ENT_W-1:0] push_data,
   input  logic             fifo_full
);
   localparam int ACC_W = 3 * SUM_W;

   logic [ACC_W-1:0] store_mem [MAX_TILES_ACROSS];
   logic [X_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ACC_W-1:0] acc_ff, rd_ff, base, sum;
   logic             bypass_ff;
   logic [COL_W-1:0] col, next_col;
   logic             accept, last_x, last_y, last_col, last_row;

   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && !fifo_full;

   assign col      = (col_ff > last_col_idx) ? last_col_idx : col_ff;
   assign last_x   = (x_ff >= last_x_idx);
   assign last_y   = (y_ff >= last_x_idx);
   assign last_col = (col >= last_col_idx);
   assign last_row = (row_ff >= last_row_idx);
   assign next_col = last_col ? '0 : col + 1'b1;

   // first segment of a tile starts from zero, later ones from the store (or the accumulator with one column)
   always_comb begin
      if (x_ff != '0) base = acc_ff;
      else if (y_ff == '0) base = '0;
      else if (bypass_ff) base = acc_ff;
      else base = rd_ff;
      sum[0 +: SUM_W]         = base[0 +: SUM_W] + SUM_W'(req_tdata[7:0]);
      sum[SUM_W +: SUM_W]     = base[SUM_W +: SUM_W] + SUM_W'(req_tdata[15:8]);
      sum[2*SUM_W +: SUM_W]   = base[2*SUM_W +: SUM_W] + SUM_W'(req_tdata[23:16]);
   end

   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (!last_x) begin
         x_in   = x_ff + 1'b1;
         col_in = col;
      end else begin
         x_in = '0;
         if (!last_col) begin
            col_in = col + 1'b1;
         end else begin
            col_in = '0;
            if (!last_y) begin
               y_in = y_ff + 1'b1;
            end else begin
               y_in   = '0;
               row_in = last_row ? '0 : row_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         x_ff   <= '0;
         y_ff   <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // segment end writes back and prefetches the next column's entry
   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= sum;
         if (last_x) begin
            store_mem[col] <= sum;
            rd_ff          <= store_mem[next_col];
            bypass_ff      <= (next_col == col);
         end
      end
   end

   assign push      = accept && last_x && last_y;
   assign push_data = {last_col && last_row, row_ff, col, sum};

endmodule

[hdl/tahd_back.sv]
// mean and dot radius computation with shared-step restoring dividers
module tahd_back import tahd_pkg::*; #(
   parameter int MAX_TILES_ACROSS = DEF_MAX_TILES_ACROSS,
   parameter int MAX_TILE_SIZE    = DEF_MAX_TILE_SIZE,
   localparam int SZ_W  = width_of(MAX_TILE_SIZE + 1),
   localparam int COL_W = width_of(MAX_TILES_ACROSS),
   localparam int SUM_W = PIX_W + width_of(MAX_TILE_SIZE * MAX_TILE_SIZE + 1),
   localparam int ENT_W = 1 + ROW_W + COL_W + 3 * SUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [SZ_W-1:0]  tile_size,
   input  logic             fifo_empty,
   input  logic [ENT_W-1:0] fifo_data,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tlast
);
   localparam int AREA_W = 2 * SZ_W;
   localparam int FULL_W = AREA_W + 10;
   localparam int NUM_W  = FULL_W + SZ_W + 3;
   localparam int W      = NUM_W + Q_W;
   localparam int CNT_W  = width_of(Q_W);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AREA = 3'd1;
   localparam logic [2:0] ST_FULL = 3'd2;
   localparam logic [2:0] ST_NUM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [ENT_W-1:0]  job_ff;
   logic [AREA_W-1:0] area_ff;
   logic [FULL_W-1:0] full_ff;
   logic [SUM_W+1:0]  total;
   logic [FULL_W-1:0] dark;
   logic [FULL_W+SZ_W-1:0] dark_sz;
   logic [W-1:0]      rem_ff [4];
   logic [Q_W-1:0]    quo_ff [4];
   logic [CNT_W-1:0]  cnt_ff;
   logic              out_load, valid_ff;
   logic [55:0]       data_ff;
   logic              last_ff;
   logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
   logic [COL_W-1:0]  job_col;
   logic [ROW_W-1:0]  job_row;
   logic [31:0]       col_wide;

   assign sum_r   = job_ff[0 +: SUM_W];
   assign sum_g   = job_ff[SUM_W +: SUM_W];
   assign sum_b   = job_ff[2*SUM_W +: SUM_W];
   assign job_col = job_ff[3*SUM_W +: COL_W];
   assign job_row = job_ff[3*SUM_W + COL_W +: ROW_W];
   assign col_wide = 32'(job_col);

   assign total = (SUM_W+2)'(sum_r) + (SUM_W+2)'(sum_g) + (SUM_W+2)'(sum_b);
   assign dark  = ((FULL_W+2)'(total) < (FULL_W+2)'(full_ff)) ?
                  full_ff - FULL_W'(total) : '0;
   assign dark_sz = (FULL_W+SZ_W)'(dark) * (FULL_W+SZ_W)'(tile_size);

   assign pop      = (state_ff == ST_IDLE) && !fifo_empty;
   assign out_load = (state_ff == ST_OUT) && (!valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!fifo_empty) state_in = ST_AREA;
         ST_AREA: state_in = ST_FULL;
         ST_FULL: state_in = ST_NUM;
         ST_NUM:  state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == '0) state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= fifo_data;
      if (state_ff == ST_AREA) area_ff <= tile_size * tile_size;
      if (state_ff == ST_FULL) full_ff <= FULL_W'(area_ff) * FULL_W'(FULL_RGB);
      if (state_ff == ST_NUM) begin
         rem_ff[0] <= W'(sum_r);
         rem_ff[1] <= W'(sum_g);
         rem_ff[2] <= W'(sum_b);
         rem_ff[3] <= W'({dark_sz, 3'b000});
         for (int k = 0; k < 4; k++) quo_ff[k] <= '0;
         cnt_ff <= CNT_W'(Q_W - 1);
      end
      // one quotient bit per cycle in each of the four dividers
      if (state_ff == ST_DIV) begin
         for (int k = 0; k < 4; k++) begin
            if (rem_ff[k] >= (((k == 3) ? W'(full_ff) : W'(area_ff)) << cnt_ff)) begin
               rem_ff[k]         <= rem_ff[k] - (((k == 3) ? W'(full_ff) : W'(area_ff)) << cnt_ff);
               quo_ff[k][cnt_ff] <= 1'b1;
            end
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (out_load) begin
         data_ff <= {2'b00, quo_ff[3], quo_ff[2][7:0], quo_ff[1][7:0], quo_ff[0][7:0],
                     job_row, col_wide[OUT_COL_W-1:0]};
         last_ff <= job_ff[ENT_W-1];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hdl/tile_average_halftone_dots.sv]
// top level of the tile average halftone dot block
// Pixels enter on req_ (tdata: red, green, blue from bit 0) in raster order
// over an image of tiles_across by tiles_down square tiles. Each pixel is
// one transaction; a pixel is taken every cycle while the tile queue has
// room. At the last pixel of a tile one transaction leaves on rsp_ with the
// tile position, the three channel means and the dot radius in eighths
// of a pixel; tlast marks the last tile of the image.
// A finished tile holds the back end through the queue pop, three
// setup steps (area, full scale, darkness product), ten steps of the four
// parallel restoring dividers, one quotient bit each per cycle, and the
// output register load, which waits while rsp_ is stalled. The back end
// takes no new tile until the last one has been loaded for output.
// The csr_ port writes tile_size, tiles_across and tiles_down by index;
// any write restarts the frame at tile zero. Reset loads 8, 80 and 60 and
// restarts the frame. When the receiver stalls rsp_, one result waits in the
// output register, one in the back end and four in the queue, after which
// req_tready drops.
module tile_average_halftone_dots import tahd_pkg::*; #(
   parameter int MAX_TILES_ACROSS = DEF_MAX_TILES_ACROSS,
   parameter int MAX_TILE_SIZE    = DEF_MAX_TILE_SIZE
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [23:0]   req_tdata,   // red, green, blue
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,   // tile_column, tile_row, mean_red, mean_green,
                                      // mean_blue, dot_radius, zero fill
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [10:0]   csr_data
);
   localparam int X_W   = width_of(MAX_TILE_SIZE);
   localparam int SZ_W  = width_of(MAX_TILE_SIZE + 1);
   localparam int COL_W = width_of(MAX_TILES_ACROSS);
   localparam int SUM_W = PIX_W + width_of(MAX_TILE_SIZE * MAX_TILE_SIZE + 1);
   localparam int ENT_W = 1 + ROW_W + COL_W + 3 * SUM_W;

   logic [6:0]       size_ff;
   logic [10:0]      across_ff, down_ff;
   logic             restart;
   logic [SZ_W-1:0]  size_c;
   logic [X_W-1:0]   last_x_idx;
   logic [COL_W-1:0] last_col_idx;
   logic [ROW_W-1:0] last_row_idx;
   logic [31:0]      across_c, down_c;
   logic             push, pop, full, empty;
   logic [ENT_W-1:0] push_data, pop_data;

   assign csr_ready = 1'b1;
   assign restart   = csr_valid && (csr_index == REG_TILE_SIZE ||
                      csr_index == REG_TILES_ACROSS || csr_index == REG_TILES_DOWN);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= RST_TILE_SIZE;
         across_ff <= RST_TILES_ACROSS;
         down_ff   <= RST_TILES_DOWN;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TILE_SIZE:    size_ff   <= csr_data[6:0];
            REG_TILES_ACROSS: across_ff <= csr_data;
            REG_TILES_DOWN:   down_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // zero acts as one, large values saturate
   always_comb begin
      if (size_ff == '0) size_c = SZ_W'(1);
      else if (32'(size_ff) > MAX_TILE_SIZE) size_c = SZ_W'(MAX_TILE_SIZE);
      else size_c = SZ_W'(size_ff);
      if (across_ff == '0) across_c = 32'd1;
      else if (32'(across_ff) > MAX_TILES_ACROSS) across_c = 32'(MAX_TILES_ACROSS);
      else across_c = 32'(across_ff);
      if (down_ff == '0) down_c = 32'd1;
      else if (32'(down_ff) > MAX_TILES_DOWN) down_c = 32'(MAX_TILES_DOWN);
      else down_c = 32'(down_ff);
   end

   assign last_x_idx   = X_W'(size_c - 1'b1);
   assign last_col_idx = COL_W'(across_c - 32'd1);
   assign last_row_idx = ROW_W'(down_c - 32'd1);

   tahd_front #(
      .MAX_TILES_ACROSS(MAX_TILES_ACROSS),
      .MAX_TILE_SIZE(MAX_TILE_SIZE)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .restart(restart),
      .last_x_idx(last_x_idx),
      .last_col_idx(last_col_idx),
      .last_row_idx(last_row_idx),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .push(push),
      .push_data(push_data),
      .fifo_full(full)
   );

   tahd_fifo #(
      .WIDTH(ENT_W)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(full),
      .pop(pop),
      .pop_data(pop_data),
      .empty(empty)
   );

   tahd_back #(
      .MAX_TILES_ACROSS(MAX_TILES_ACROSS),
      .MAX_TILE_SIZE(MAX_TILE_SIZE)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .tile_size(size_c),
      .fifo_empty(empty),
      .fifo_data(pop_data),
      .pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule
